/* src/speed_command_frame_encoder_assert.svh */
// assertion macros shared by the speed command frame encoder rtl
`ifndef SPEED_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define SPEED_COMMAND_FRAME_ENCODER_ASSERT_SVH

// property checked on every clock edge outside reset
`define SCFE_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define SCFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/scfe_pkg.sv */
// shared types and constants of the speed command frame encoder
`default_nettype none

package scfe_pkg;

  localparam int unsigned RPM_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  // rpm * 35 fits in 22 bits
  localparam int unsigned PROD_W   = 22;
  // scaled value is at most 764575
  localparam int unsigned SCALED_W = 20;

  // rpm * 700 / 60 == rpm * 35 / 3
  localparam logic [PROD_W-1:0] SCALE_MUL = PROD_W'(35);
  // ceil(2^23 / 3), exact floor division by 3 for values below 2^23
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP_DIV3 = RECIP_W'(2796203);

  // fixed header bytes
  localparam logic [BYTE_W-1:0] SYNC0_BYTE = BYTE_W'(2);
  localparam logic [BYTE_W-1:0] SYNC1_BYTE = BYTE_W'(3);
  localparam logic [BYTE_W-1:0] ID_BYTE    = BYTE_W'(0);
  localparam logic [BYTE_W-1:0] LEN_BYTE   = BYTE_W'(4);

  // byte positions within a frame, in transmit order
  typedef enum logic [3:0] {
    POS_SYNC0 = 4'd0,
    POS_SYNC1 = 4'd1,
    POS_ID0   = 4'd2,
    POS_ID1   = 4'd3,
    POS_LEN   = 4'd4,
    POS_D0    = 4'd5,
    POS_D1    = 4'd6,
    POS_D2    = 4'd7,
    POS_D3    = 4'd8,
    POS_CKA   = 4'd9,
    POS_CKB   = 4'd10
  } scfe_pos_t;

  // one scaled command from the front end to the queue
  typedef struct packed {
    logic                valid;
    logic [SCALED_W-1:0] scaled;
  } scfe_cmd_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } scfe_qstat_t;

endpackage

`default_nettype wire

/* src/scfe_front.sv */
// front end: accepts speed commands and scales them to erps x 100
`default_nettype none

module scfe_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [scfe_pkg::RPM_W-1:0]        speed_rpm,
  input  wire scfe_pkg::scfe_qstat_t             qstat,
  output scfe_pkg::scfe_cmd_t                    push
);
  import scfe_pkg::*;

  localparam int unsigned WIDE_W = PROD_W + RECIP_W;

  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod;
  logic              s2_valid;
  logic [SCALED_W-1:0] s2_scaled;
  logic              s1_free;
  logic              s2_load;
  logic [WIDE_W-1:0] recip_prod;

  // stage handoff: stage 2 drains into the queue when it has room
  assign s2_load = !s2_valid || !qstat.full;
  assign s1_free = !s1_valid || s2_load;
  assign busy    = !s1_free;

  // divide by 3 through the reciprocal
  assign recip_prod = WIDE_W'(s1_prod) * WIDE_W'(RECIP_DIV3);

  // stage 1: rpm * 35
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= start;
    end
    if (s1_free && start) begin
      s1_prod <= PROD_W'(speed_rpm) * SCALE_MUL;
    end
  end

  // stage 2: truncated quotient by 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
    if (s2_load && s1_valid) begin
      s2_scaled <= recip_prod[RECIP_SHIFT +: SCALED_W];
    end
  end

  assign push.valid  = s2_valid && !qstat.full;
  assign push.scaled = s2_scaled;

endmodule

`default_nettype wire

/* src/scfe_queue.sv */
// two-entry command queue between front end and frame sequencer
`default_nettype none

`include "speed_command_frame_encoder_assert.svh"

module scfe_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scfe_pkg::scfe_cmd_t   push,
  input  wire logic                  pop,
  output scfe_pkg::scfe_qstat_t      qstat,
  output logic [scfe_pkg::SCALED_W-1:0] head
);
  import scfe_pkg::*;

  logic [SCALED_W-1:0] entry [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_pop;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign head        = entry[rd_ptr];
  assign do_pop      = pop && !qstat.empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wr_ptr] <= push.scaled;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push.valid, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `SCFE_ASSERT_CLK(a_no_push_when_full, !(push.valid && qstat.full), "push into full queue")
  `SCFE_ASSERT_ALWAYS(a_count_bound, rst || (count != 2'd3), "queue count out of range")

endmodule

`default_nettype wire

/* src/scfe_back.sv */
// frame sequencer: emits one frame byte per cycle while a frame is active, with running checksums
`default_nettype none

`include "speed_command_frame_encoder_assert.svh"

module scfe_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire scfe_pkg::scfe_qstat_t         qstat,
  input  wire logic [scfe_pkg::SCALED_W-1:0] head,
  output logic                               pop,
  output logic                               strobe,
  output logic [scfe_pkg::BYTE_W-1:0]        frame_byte,
  output logic                               last_byte
);
  import scfe_pkg::*;

  logic                active;
  scfe_pos_t           pos;
  logic [SCALED_W-1:0] scaled;
  logic [BYTE_W-1:0]   sum_a;
  logic [BYTE_W-1:0]   sum_b;
  logic [31:0]         word;
  logic [BYTE_W-1:0]   cur_byte;
  logic [BYTE_W-1:0]   sum_a_next;
  logic                frame_end;

  assign frame_end = active && (pos == POS_CKB);
  // next command starts right after the last byte of the current one
  assign pop       = !qstat.empty && (!active || frame_end);
  assign word      = 32'(scaled);

  // byte select for the current position
  always_comb begin
    unique case (pos)
      POS_SYNC0: cur_byte = SYNC0_BYTE;
      POS_SYNC1: cur_byte = SYNC1_BYTE;
      POS_ID0:   cur_byte = ID_BYTE;
      POS_ID1:   cur_byte = ID_BYTE;
      POS_LEN:   cur_byte = LEN_BYTE;
      POS_D0:    cur_byte = word[7:0];
      POS_D1:    cur_byte = word[15:8];
      POS_D2:    cur_byte = word[23:16];
      POS_D3:    cur_byte = word[31:24];
      POS_CKA:   cur_byte = sum_a;
      POS_CKB:   cur_byte = sum_b;
      default:   cur_byte = '0;
    endcase
  end

  assign sum_a_next = sum_a + cur_byte;

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      pos    <= POS_SYNC0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        pos    <= POS_SYNC0;
      end else if (frame_end) begin
        active <= 1'b0;
      end else if (active) begin
        pos <= scfe_pos_t'(pos + 4'd1);
      end
    end
  end

  // output byte and checksum accumulation
  always_ff @(posedge clk) begin
    if (active) begin
      frame_byte <= cur_byte;
      last_byte  <= (pos == POS_CKB);
    end
    if (pop) begin
      scaled <= head;
      sum_a  <= '0;
      sum_b  <= '0;
    end else if (active && (pos != POS_CKA) && (pos != POS_CKB)) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b + sum_a_next;
    end
  end

  `SCFE_ASSERT_CLK(a_frame_contiguous, strobe && !last_byte |=> strobe, "gap inside a frame")
  `SCFE_ASSERT_CLK(a_last_from_ckb, strobe && last_byte |-> $past(pos) == POS_CKB, "bad last byte")

endmodule

`default_nettype wire

/* src/speed_command_frame_encoder.sv */
// top level of the speed command frame encoder
//
// channel   direction  handshake            payload
// command   in         start / busy         speed_rpm[15:0]
// frame     out        strobe (no stall)    frame_byte[7:0], last_byte
//
// each command gives 11 bytes, one per cycle; frames follow each other
// without gaps while commands are waiting in the queue.
// a command passes the two multiplier stages, the queue, the sequencer state
// register and the sequencer output register before its first byte leaves.
// busy rises only when both multiplier stages and the two-entry queue hold
// commands; synchronous reset clears all control, no clearing pass is needed.
`default_nettype none

module speed_command_frame_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [scfe_pkg::RPM_W-1:0]  speed_rpm,
  output logic                             strobe,
  output logic [scfe_pkg::BYTE_W-1:0]      frame_byte,
  output logic                             last_byte
);
  import scfe_pkg::*;

  scfe_cmd_t           push;
  scfe_qstat_t         qstat;
  logic [SCALED_W-1:0] head;
  logic                pop;

  // scaling front end
  scfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .speed_rpm (speed_rpm),
    .qstat     (qstat),
    .push      (push)
  );

  // command queue
  scfe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  // frame sequencer
  scfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .strobe     (strobe),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench of the speed command frame encoder
module testbench;
  import scfe_pkg::*;

  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [RPM_W-1:0]  speed_rpm = '0;
  logic              busy;
  logic              strobe;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;

  // expected frame bytes, oldest first
  logic [BYTE_W-1:0] pending_bytes[$];
  logic              pending_last[$];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned gap_pct = 0;

  speed_command_frame_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .speed_rpm  (speed_rpm),
    .strobe     (strobe),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // build the frame a speed command should produce
  function automatic void predict_frame(input logic [RPM_W-1:0] rpm);
    logic [31:0]       scaled;
    logic [BYTE_W-1:0] body[9];
    logic [BYTE_W-1:0] cka;
    logic [BYTE_W-1:0] ckb;
    int                i;
    scaled = (32'(rpm) * 32'd700) / 32'd60;
    body[0] = SYNC0_BYTE;
    body[1] = SYNC1_BYTE;
    body[2] = ID_BYTE;
    body[3] = ID_BYTE;
    body[4] = LEN_BYTE;
    body[5] = scaled[7:0];
    body[6] = scaled[15:8];
    body[7] = scaled[23:16];
    body[8] = scaled[31:24];
    cka = '0;
    ckb = '0;
    // running sums over the header and payload
    for (i = 0; i < 9; i++) begin
      cka = cka + body[i];
      ckb = ckb + cka;
      pending_bytes.push_back(body[i]);
      pending_last.push_back(1'b0);
    end
    pending_bytes.push_back(cka);
    pending_last.push_back(1'b0);
    pending_bytes.push_back(ckb);
    pending_last.push_back(1'b1);
  endfunction

  // one command transaction, with a random gap in front of it
  task automatic send_speed(input logic [RPM_W-1:0] rpm);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    speed_rpm <= rpm;
    do
      @(posedge clk);
    while (busy);
    predict_frame(rpm);
  endtask

  // random speed, weighted toward the ends of the range
  function automatic logic [RPM_W-1:0] pick_speed();
    case ($urandom_range(3))
      0: pick_speed = RPM_W'($urandom_range(255));
      1: pick_speed = RPM_W'(65535 - $urandom_range(255));
      default: pick_speed = RPM_W'($urandom);
    endcase
  endfunction

  // compare each frame byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none actual %02h last %0b",
                 $time, frame_byte, last_byte);
        mismatch_count++;
      end else begin
        if (frame_byte !== pending_bytes[0]) begin
          $display("%0t: frame_byte expected %02h actual %02h",
                   $time, pending_bytes[0], frame_byte);
          mismatch_count++;
        end
        if (last_byte !== pending_last[0]) begin
          $display("%0t: last_byte expected %0b actual %0b",
                   $time, pending_last[0], last_byte);
          mismatch_count++;
        end
        void'(pending_bytes.pop_front());
        void'(pending_last.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction and no frame byte
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // field extremes, single bits, truncation and checksum wrap
  task automatic test_directed();
    send_speed(16'd0);
    send_speed(16'd1);
    send_speed(16'd2);
    send_speed(16'd5);
    send_speed(16'd6);
    send_speed(16'd59);
    send_speed(16'd60);
    send_speed(16'd61);
    send_speed(16'd65535);
    send_speed(16'd65534);
    send_speed(16'h8000);
    send_speed(16'h5555);
    send_speed(16'hAAAA);
    send_speed(16'h00FF);
    send_speed(16'hFF00);
    send_speed(16'd1000);
    send_speed(16'd3000);
    send_speed(16'd22469);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_speed(pick_speed());
  endtask

  // hold commands back until every expected byte is out
  task automatic test_drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    send_speed(pick_speed());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 21;
    test_directed();
    test_random(25);
    test_drain_pause();

    gap_pct = 47;
    test_random(28);

    gap_pct = 0;
    test_random(28);

    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
